@@ rtl/core/pairwise_gravity_accumulator_2d_macros.svh @@
// assertion macros shared by the rtl
`ifndef PAIRWISE_GRAVITY_ACCUMULATOR_2D_MACROS_SVH
`define PAIRWISE_GRAVITY_ACCUMULATOR_2D_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define PGA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pga assertion failed");
// condition must never be true outside reset
`define PGA_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("pga forbidden condition");
`else
`define PGA_ASSERT(label, clk, rst, prop)
`define PGA_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

@@ rtl/core/pga_pkg.sv @@
package pga_pkg;

   localparam int POS_FRAC_BITS = 16;

   localparam int POS_W      = 32;
   localparam int DIFF_W     = 33;
   localparam int GM_W       = 64;
   localparam int R2_W       = 66;
   localparam int ROOT_W     = 35;
   localparam int MUL_W      = 101;
   localparam int NUM_W      = 128;
   localparam int ACC_W      = 48;
   localparam int SQ_REM_W   = 38;
   localparam int SQ_SRC_W   = 2 * ROOT_W;
   localparam int MUL_STEPS  = ROOT_W;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = ACC_W;
   localparam int CNT_W      = 6;

   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_CHECK = 13'b0000000000010,
      ST_SQX   = 13'b0000000000100,
      ST_SQY   = 13'b0000000001000,
      ST_SQRT  = 13'b0000000010000,
      ST_DEN   = 13'b0000000100000,
      ST_NUMX  = 13'b0000001000000,
      ST_DIVX  = 13'b0000010000000,
      ST_ACCX  = 13'b0000100000000,
      ST_NUMY  = 13'b0001000000000,
      ST_DIVY  = 13'b0010000000000,
      ST_ACCY  = 13'b0100000000000,
      ST_FIN   = 13'b1000000000000
   } state_type;

   typedef enum logic [1:0] {
      MUL_SQX = 2'd0,
      MUL_SQY = 2'd1,
      MUL_DEN = 2'd2,
      MUL_NUM = 2'd3
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        check;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        sqrt_en;
      logic        div_en;
      logic        init;
      logic        acc;
      logic        sel_y;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic zero;
      logic last;
   } status_type;

endpackage

@@ rtl/core/pga_ctrl.sv @@
`include "pairwise_gravity_accumulator_2d_macros.svh"

module pga_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  pga_pkg::status_type  status,
   output pga_pkg::cmd_type     cmd
);

   pga_pkg::state_type          state_ff, state_in;
   logic [pga_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        iter;
   logic [pga_pkg::CNT_W-1:0]   limit;
   logic                        done;

   always_comb begin
      iter  = 1'b1;
      limit = pga_pkg::CNT_W'(pga_pkg::MUL_STEPS);
      unique case (state_ff)
         pga_pkg::ST_SQRT: limit = pga_pkg::CNT_W'(pga_pkg::SQRT_STEPS);
         pga_pkg::ST_DIVX, pga_pkg::ST_DIVY: limit = pga_pkg::CNT_W'(pga_pkg::DIV_STEPS);
         pga_pkg::ST_SQX, pga_pkg::ST_SQY, pga_pkg::ST_DEN,
         pga_pkg::ST_NUMX, pga_pkg::ST_NUMY: iter = 1'b1;
         default: iter = 1'b0;
      endcase
   end

   assign done = iter && (cnt_ff == limit);

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.init    = (cnt_ff == '0);
      cmd.mul_sel = pga_pkg::MUL_SQX;
      unique case (state_ff)
         pga_pkg::ST_IDLE: begin
            cmd.load = req_tvalid;
            if (req_tvalid) state_in = pga_pkg::ST_CHECK;
         end
         pga_pkg::ST_CHECK: begin
            cmd.check = 1'b1;
            if (status.skip || status.zero) state_in = pga_pkg::ST_FIN;
            else state_in = pga_pkg::ST_SQX;
         end
         pga_pkg::ST_SQX: begin
            cmd.mul_en = 1'b1;
            if (done) state_in = pga_pkg::ST_SQY;
         end
         pga_pkg::ST_SQY: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pga_pkg::MUL_SQY;
            if (done) state_in = pga_pkg::ST_SQRT;
         end
         pga_pkg::ST_SQRT: begin
            cmd.sqrt_en = 1'b1;
            if (done) state_in = pga_pkg::ST_DEN;
         end
         pga_pkg::ST_DEN: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pga_pkg::MUL_DEN;
            if (done) state_in = pga_pkg::ST_NUMX;
         end
         pga_pkg::ST_NUMX: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pga_pkg::MUL_NUM;
            if (done) state_in = pga_pkg::ST_DIVX;
         end
         pga_pkg::ST_DIVX: begin
            cmd.div_en = 1'b1;
            if (done) state_in = pga_pkg::ST_ACCX;
         end
         pga_pkg::ST_ACCX: begin
            cmd.acc  = 1'b1;
            state_in = pga_pkg::ST_NUMY;
         end
         pga_pkg::ST_NUMY: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pga_pkg::MUL_NUM;
            cmd.sel_y   = 1'b1;
            if (done) state_in = pga_pkg::ST_DIVY;
         end
         pga_pkg::ST_DIVY: begin
            cmd.div_en = 1'b1;
            cmd.sel_y  = 1'b1;
            if (done) state_in = pga_pkg::ST_ACCY;
         end
         pga_pkg::ST_ACCY: begin
            cmd.acc   = 1'b1;
            cmd.sel_y = 1'b1;
            state_in  = pga_pkg::ST_FIN;
         end
         pga_pkg::ST_FIN: begin
            if (!status.last) begin
               state_in = pga_pkg::ST_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               cmd.emit = 1'b1;
               state_in = pga_pkg::ST_IDLE;
            end
         end
         default: state_in = pga_pkg::ST_IDLE;
      endcase
   end

   assign cnt_in       = (iter && !done) ? cnt_ff + 1'b1 : '0;
   assign rsp_valid_in = cmd.emit | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pga_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == pga_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // a pending result is never overwritten
   `PGA_ASSERT(a_emit_free, clock, reset, cmd.emit |-> (!rsp_valid_ff || rsp_tready))
   // step counter stays within the longest iteration
   `PGA_ASSERT_NEVER(a_cnt_range, clock, reset,
      cnt_ff > pga_pkg::CNT_W'(pga_pkg::DIV_STEPS))
   // an accepted request goes straight to the check step
   `PGA_ASSERT(a_load_check, clock, reset,
      (req_tvalid && req_tready) |=> (state_ff == pga_pkg::ST_CHECK))

endmodule

@@ rtl/core/pga_datapath.sv @@
`include "pairwise_gravity_accumulator_2d_macros.svh"

module pga_datapath #(
   parameter int POS_FRAC_BITS = pga_pkg::POS_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pga_pkg::cmd_type              cmd,
   output pga_pkg::status_type           status,
   input  logic [pga_pkg::POS_W-1:0]     target_x,
   input  logic [pga_pkg::POS_W-1:0]     target_y,
   input  logic [pga_pkg::POS_W-1:0]     source_x,
   input  logic [pga_pkg::POS_W-1:0]     source_y,
   input  logic [pga_pkg::POS_W-1:0]     source_mass,
   input  logic                          skip_self,
   input  logic                          first_item,
   input  logic                          last_item,
   input  logic [pga_pkg::POS_W-1:0]     grav_constant,
   output logic [pga_pkg::ACC_W-1:0]     accel_x,
   output logic [pga_pkg::ACC_W-1:0]     accel_y,
   output logic                          coincident_seen,
   output logic                          saturated
);

   localparam int DW  = pga_pkg::DIFF_W;
   localparam int MW  = pga_pkg::MUL_W;
   localparam int RW  = pga_pkg::ROOT_W;
   localparam int AW  = pga_pkg::ACC_W;
   localparam int NW  = pga_pkg::NUM_W;
   localparam int SRW = pga_pkg::SQ_REM_W;
   localparam int SSW = pga_pkg::SQ_SRC_W;

   // operand capture
   logic [DW-1:0]  dx, dy;
   logic [DW-1:0]  ax_ff, ay_ff;
   logic           sign_x_ff, sign_y_ff, zero_ff, skip_ff, last_ff;
   logic [pga_pkg::POS_W-1:0] mass_ff;
   logic [pga_pkg::GM_W-1:0]  gm_ff;

   // shift-add multiplier
   logic [MW-1:0]  mul_a_ff, mul_acc_ff;
   logic [RW-1:0]  mul_b_ff;

   // square root
   logic [pga_pkg::R2_W-1:0] r2_ff;
   logic [SSW-1:0] sq_src_ff;
   logic [SRW-1:0] sq_rem_ff, sq_rem_sh, sq_trial;
   logic [RW-1:0]  root_ff;

   // restoring divider
   logic [NW-1:0]  num;
   logic [MW-1:0]  den_ff, div_rem_ff;
   logic [MW:0]    div_rem_sh;
   logic [AW-1:0]  div_lo_ff, q_ff;
   logic           over_ff;

   // accumulate
   logic [AW-1:0]  sum_x_ff, sum_y_ff, lim, qc, term, sum_cur, sum_new;
   logic [AW:0]    sum_wide;
   logic           coin_ff, sat_ff, term_sat, sum_sat, sign_cur;
   logic [AW-1:0]  out_x_ff, out_y_ff;
   logic           out_coin_ff, out_sat_ff;

   assign dx = {source_x[pga_pkg::POS_W-1], source_x} - {target_x[pga_pkg::POS_W-1], target_x};
   assign dy = {source_y[pga_pkg::POS_W-1], source_y} - {target_y[pga_pkg::POS_W-1], target_y};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sign_x_ff <= dx[DW-1];
         sign_y_ff <= dy[DW-1];
         ax_ff     <= dx[DW-1] ? (~dx + 1'b1) : dx;
         ay_ff     <= dy[DW-1] ? (~dy + 1'b1) : dy;
         zero_ff   <= (dx == '0) && (dy == '0);
         skip_ff   <= skip_self;
         last_ff   <= last_item;
         mass_ff   <= source_mass;
      end
      if (cmd.check) gm_ff <= grav_constant * mass_ff;
   end

   // multiplier: init loads operands, then one multiplier bit per cycle
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         if (cmd.init) begin
            case (cmd.mul_sel)
               pga_pkg::MUL_SQX: begin
                  mul_a_ff   <= MW'(ax_ff);
                  mul_b_ff   <= RW'(ax_ff);
                  mul_acc_ff <= '0;
               end
               pga_pkg::MUL_SQY: begin
                  mul_a_ff <= MW'(ay_ff);
                  mul_b_ff <= RW'(ay_ff);
               end
               pga_pkg::MUL_DEN: begin
                  mul_a_ff   <= MW'(r2_ff);
                  mul_b_ff   <= root_ff;
                  mul_acc_ff <= '0;
               end
               default: begin
                  mul_a_ff   <= MW'(gm_ff);
                  mul_b_ff   <= cmd.sel_y ? RW'(ay_ff) : RW'(ax_ff);
                  mul_acc_ff <= '0;
                  if (!cmd.sel_y) den_ff <= mul_acc_ff;
               end
            endcase
         end else begin
            if (mul_b_ff[0]) mul_acc_ff <= mul_acc_ff + mul_a_ff;
            mul_a_ff <= {mul_a_ff[MW-2:0], 1'b0};
            mul_b_ff <= {1'b0, mul_b_ff[RW-1:1]};
         end
      end
   end

   // square root, two radicand bits per step
   assign sq_rem_sh = {sq_rem_ff[SRW-3:0], sq_src_ff[SSW-1 -: 2]};
   assign sq_trial  = SRW'({root_ff, 2'b01});

   always_ff @(posedge clock) begin
      if (cmd.sqrt_en) begin
         if (cmd.init) begin
            r2_ff     <= mul_acc_ff[pga_pkg::R2_W-1:0];
            sq_src_ff <= SSW'(mul_acc_ff[pga_pkg::R2_W-1:0]);
            sq_rem_ff <= '0;
            root_ff   <= '0;
         end else begin
            sq_src_ff <= {sq_src_ff[SSW-3:0], 2'b00};
            if (sq_rem_sh >= sq_trial) begin
               sq_rem_ff <= sq_rem_sh - sq_trial;
               root_ff   <= {root_ff[RW-2:0], 1'b1};
            end else begin
               sq_rem_ff <= sq_rem_sh;
               root_ff   <= {root_ff[RW-2:0], 1'b0};
            end
         end
      end
   end

   // divider: upper quotient bits only decide overflow
   assign num        = NW'(mul_acc_ff) << POS_FRAC_BITS;
   assign div_rem_sh = {div_rem_ff, div_lo_ff[AW-1]};

   always_ff @(posedge clock) begin
      if (cmd.div_en) begin
         if (cmd.init) begin
            over_ff    <= MW'(num[NW-1:AW]) >= den_ff;
            div_rem_ff <= MW'(num[NW-1:AW]);
            div_lo_ff  <= num[AW-1:0];
            q_ff       <= '0;
         end else begin
            div_lo_ff <= {div_lo_ff[AW-2:0], 1'b0};
            if (div_rem_sh >= {1'b0, den_ff}) begin
               div_rem_ff <= MW'(div_rem_sh - {1'b0, den_ff});
               q_ff       <= {q_ff[AW-2:0], 1'b1};
            end else begin
               div_rem_ff <= div_rem_sh[MW-1:0];
               q_ff       <= {q_ff[AW-2:0], 1'b0};
            end
         end
      end
   end

   // clamp the term, then add with saturation
   assign sign_cur = cmd.sel_y ? sign_y_ff : sign_x_ff;
   assign lim      = sign_cur ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
   assign term_sat = over_ff || (q_ff > lim);
   assign qc       = term_sat ? lim : q_ff;
   assign term     = sign_cur ? (~qc + 1'b1) : qc;
   assign sum_cur  = cmd.sel_y ? sum_y_ff : sum_x_ff;
   assign sum_wide = {sum_cur[AW-1], sum_cur} + {term[AW-1], term};
   assign sum_sat  = sum_wide[AW] != sum_wide[AW-1];
   assign sum_new  = !sum_sat ? sum_wide[AW-1:0] :
                     sum_wide[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         coin_ff  <= 1'b0;
         sat_ff   <= 1'b0;
      end else if ((cmd.load && first_item) || cmd.emit) begin
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         coin_ff  <= 1'b0;
         sat_ff   <= 1'b0;
      end else begin
         if (cmd.check && !skip_ff && zero_ff) coin_ff <= 1'b1;
         if (cmd.acc) begin
            if (cmd.sel_y) sum_y_ff <= sum_new;
            else sum_x_ff <= sum_new;
            if (term_sat || sum_sat) sat_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_x_ff    <= sum_x_ff;
         out_y_ff    <= sum_y_ff;
         out_coin_ff <= coin_ff;
         out_sat_ff  <= sat_ff;
      end
   end

   assign status.skip     = skip_ff;
   assign status.zero     = zero_ff;
   assign status.last     = last_ff;
   assign accel_x         = out_x_ff;
   assign accel_y         = out_y_ff;
   assign coincident_seen = out_coin_ff;
   assign saturated       = out_sat_ff;

   // restoring step keeps remainder below divisor
   `PGA_ASSERT(a_div_rem, clock, reset,
      (cmd.div_en && !cmd.init && !over_ff) |=> (div_rem_ff < den_ff))
   // coincident non-self source raises the flag
   `PGA_ASSERT(a_coin_set, clock, reset,
      (cmd.check && !skip_ff && zero_ff) |=> coin_ff)
   // emitted result clears running state
   `PGA_ASSERT(a_emit_clear, clock, reset,
      cmd.emit |=> (sum_x_ff == '0 && sum_y_ff == '0 && !coin_ff && !sat_ff))

endmodule

@@ rtl/core/pairwise_gravity_accumulator_2d.sv @@
// direct-sum 2d gravity: each request carries a target position, one source position and
// mass; the block adds g*m*d/|d|^3 (d = source - target) into 48-bit saturating sums and
// sends one response after the request marked last. a request with skip_self set, or a
// source at zero distance, skips the arithmetic; any other source goes through the
// shared bit-serial multiplier (five products at one multiplier bit a cycle), the one-bit-
// per-cycle square root and the one-quotient-bit-per-cycle divider run for x and y. a
// finished response waits in an output register, so the next request is taken meanwhile.
// grav_constant sits at byte address 0 of the csr port and resets to 1.
module pairwise_gravity_accumulator_2d #(
   parameter int POS_FRAC_BITS = pga_pkg::POS_FRAC_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // target_x, target_y, source_x, source_y, source_mass
   input  logic [159:0] req_tdata,
   // skip_self, first_item
   input  logic [1:0]   req_tuser,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // accel_x, accel_y
   output logic [95:0]  rsp_tdata,
   // coincident_seen, saturated
   output logic [1:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   pga_pkg::cmd_type    cmd;
   pga_pkg::status_type status;
   logic [31:0]         grav_ff;
   logic                csr_wr;

   // register write on the access phase, register 0 only
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];
   assign csr_prdata = csr_paddr[2] ? 32'd0 : grav_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff <= 32'd1;
      end else if (csr_wr) begin
         grav_ff <= csr_pwdata;
      end
   end

   // sequencer
   pga_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // arithmetic and accumulators
   pga_datapath #(
      .POS_FRAC_BITS (POS_FRAC_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .target_x        (req_tdata[31:0]),
      .target_y        (req_tdata[63:32]),
      .source_x        (req_tdata[95:64]),
      .source_y        (req_tdata[127:96]),
      .source_mass     (req_tdata[159:128]),
      .skip_self       (req_tuser[0]),
      .first_item      (req_tuser[1]),
      .last_item       (req_tlast),
      .grav_constant   (grav_ff),
      .accel_x         (rsp_tdata[47:0]),
      .accel_y         (rsp_tdata[95:48]),
      .coincident_seen (rsp_tuser[0]),
      .saturated       (rsp_tuser[1])
   );

endmodule

@@ test/tb_pairwise_gravity_accumulator_2d.sv @@
module tb_pairwise_gravity_accumulator_2d;
   import pga_pkg::*;

   // csr map: grav_constant is the only register
   localparam logic [2:0] ADDR_GRAV_CONSTANT = 3'd0;
   localparam logic [31:0] GRAV_RESET = 32'd1;
   // longest correct pause with no handshake: one full source plus the long receiver
   // hold-off, with generous margin
   localparam int IDLE_LIMIT = 20000;
   // cycles to let a non-emitting request finish before touching the csr
   localparam int DRAIN_CYCLES = 400;
   localparam int HOLD_CYCLES = 3000;
   localparam int RAND_PER_PHASE = 360;

   typedef struct {
      logic [31:0] target_x;
      logic [31:0] target_y;
      logic [31:0] source_x;
      logic [31:0] source_y;
      logic [31:0] source_mass;
      logic        skip_self;
      logic        first_item;
      logic        last_item;
   } body_req_t;

   typedef struct {
      logic [47:0] accel_x;
      logic [47:0] accel_y;
      logic        coincident_seen;
      logic        saturated;
   } accel_rsp_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // target_x, target_y, source_x, source_y, source_mass (lowest bits first)
   logic [159:0] req_tdata = '0;
   // skip_self, first_item
   logic [1:0]   req_tuser = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // accel_x, accel_y
   logic [95:0]  rsp_tdata;
   // coincident_seen, saturated
   logic [1:0]   rsp_tuser;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   pairwise_gravity_accumulator_2d u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state, mirrors the block's accumulators
   logic [31:0]        grav_k = GRAV_RESET;
   logic signed [47:0] acc_x = '0;
   logic signed [47:0] acc_y = '0;
   logic               coinc_flag = 1'b0;
   logic               sat_flag = 1'b0;

   body_req_t  pending_bodies[$];
   accel_rsp_t expected_accels[$];

   int n_accepted = 0;
   int n_results = 0;
   int n_mismatch = 0;
   int n_coinc = 0;
   int n_sat = 0;
   int n_writes = 0;
   int idle_cycles = 0;
   int req_gap = 0;
   int rsp_stall = 0;
   int hold_left = 0;
   bit no_idle = 0;

   // one axis term: floor(gm*|d|*2^F / den) with the sign of d, clamped to 48 bits
   function automatic logic signed [47:0] axis_term(logic [32:0] d, logic [63:0] gm,
                                                    logic [127:0] den);
      logic         neg;
      logic [127:0] mag;
      logic [127:0] num;
      logic [127:0] quo;
      logic [127:0] lim;
      neg = d[32];
      mag = {95'd0, neg ? (~d + 33'd1) : d};
      num = (128'(gm) * mag) << POS_FRAC_BITS;
      quo = num / den;
      lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 128'd1);
      if (quo > lim) begin
         sat_flag = 1'b1;
         quo = lim;
      end
      return neg ? -48'(quo) : 48'(quo);
   endfunction

   function automatic logic signed [47:0] sat_add(logic signed [47:0] a,
                                                  logic signed [47:0] b);
      logic signed [48:0] s;
      s = 49'(a) + 49'(b);
      if (s > 49'sh0_7FFF_FFFF_FFFF) begin
         sat_flag = 1'b1;
         return 48'sh7FFF_FFFF_FFFF;
      end
      if (s < -49'sh0_8000_0000_0000) begin
         sat_flag = 1'b1;
         return 48'sh8000_0000_0000;
      end
      return s[47:0];
   endfunction

   // fold one accepted source into the sums; queue a result on the last mark
   function automatic void accumulate_body(body_req_t b);
      logic [32:0]  dx;
      logic [32:0]  dy;
      logic [127:0] ax;
      logic [127:0] ay;
      logic [127:0] r2;
      logic [127:0] root;
      logic [127:0] c;
      logic [127:0] den;
      accel_rsp_t   r;
      dx = {b.source_x[31], b.source_x} - {b.target_x[31], b.target_x};
      dy = {b.source_y[31], b.source_y} - {b.target_y[31], b.target_y};
      if (b.first_item) begin
         acc_x = '0;
         acc_y = '0;
         coinc_flag = 1'b0;
         sat_flag = 1'b0;
      end
      if (!b.skip_self) begin
         if (dx == '0 && dy == '0) begin
            coinc_flag = 1'b1;
         end else begin
            ax = {95'd0, dx[32] ? (~dx + 33'd1) : dx};
            ay = {95'd0, dy[32] ? (~dy + 33'd1) : dy};
            r2 = ax * ax + ay * ay;
            root = '0;
            for (int i = 34; i >= 0; i--) begin
               c = root | (128'd1 << i);
               if (c * c <= r2) root = c;
            end
            den = r2 * root;
            acc_x = sat_add(acc_x, axis_term(dx, 64'(grav_k) * 64'(b.source_mass), den));
            acc_y = sat_add(acc_y, axis_term(dy, 64'(grav_k) * 64'(b.source_mass), den));
         end
      end
      if (b.last_item) begin
         r.accel_x = acc_x;
         r.accel_y = acc_y;
         r.coincident_seen = coinc_flag;
         r.saturated = sat_flag;
         expected_accels.push_back(r);
         acc_x = '0;
         acc_y = '0;
         coinc_flag = 1'b0;
         sat_flag = 1'b0;
      end
   endfunction

   // request driver: one gap draw per request, predicts on acceptance
   always @(posedge clock) begin
      body_req_t nb;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            accumulate_body('{req_tdata[31:0], req_tdata[63:32], req_tdata[95:64],
                              req_tdata[127:96], req_tdata[159:128], req_tuser[0],
                              req_tuser[1], req_tlast});
            n_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_bodies.size() > 0) begin
               nb = pending_bodies.pop_front();
               req_tdata <= {nb.source_mass, nb.source_y, nb.source_x, nb.target_y,
                             nb.target_x};
               req_tuser <= {nb.first_item, nb.skip_self};
               req_tlast <= nb.last_item;
               req_tvalid <= 1'b1;
               req_gap = no_idle ? 0 : $urandom_range(0, 10);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor: compares against the oldest predicted acceleration
   always @(posedge clock) begin
      accel_rsp_t e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            n_results++;
            if (expected_accels.size() == 0) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("unexpected response: accel_x=%h accel_y=%h flags=%b",
                           rsp_tdata[47:0], rsp_tdata[95:48], rsp_tuser);
            end else begin
               e = expected_accels.pop_front();
               if (e.coincident_seen) n_coinc++;
               if (e.saturated) n_sat++;
               if (rsp_tdata[47:0] !== e.accel_x || rsp_tdata[95:48] !== e.accel_y ||
                   rsp_tuser[0] !== e.coincident_seen || rsp_tuser[1] !== e.saturated) begin
                  n_mismatch++;
                  if (n_mismatch <= 10)
                     $display("mismatch #%0d: exp x=%h y=%h coinc=%b sat=%b,",
                              n_results, e.accel_x, e.accel_y, e.coincident_seen,
                              e.saturated, " got x=%h y=%h coinc=%b sat=%b",
                              rsp_tdata[47:0], rsp_tdata[95:48],
                              rsp_tuser[0], rsp_tuser[1]);
               end
            end
            rsp_stall = no_idle ? 0 : $urandom_range(0, 10);
         end
         // long hold-off first, then the per-response stall
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no handshake of any kind
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable) || reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("** pairwise_gravity_accumulator_2d: FAILED **");
            $finish;
         end
      end
   end

   function automatic body_req_t mk_body(logic [31:0] tx, logic [31:0] ty, logic [31:0] sx,
                                         logic [31:0] sy, logic [31:0] m, logic skip,
                                         logic first, logic last);
      body_req_t b;
      b = '{tx, ty, sx, sy, m, skip, first, last};
      return b;
   endfunction

   task automatic write_grav(logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_GRAV_CONSTANT;
      csr_pwdata <= value;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      grav_k = value;
      n_writes++;
   endtask

   // wait until every request is in and answered, then let a trailing
   // non-emitting source finish inside the block
   task automatic drain();
      while (pending_bodies.size() > 0 || req_tvalid || expected_accels.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one target with a short, mostly well-formed run of sources
   task automatic add_random_set();
      int          len;
      int          spread;
      logic [31:0] tx;
      logic [31:0] ty;
      logic [31:0] sx;
      logic [31:0] sy;
      logic [31:0] m;
      bit          wide_mode;
      len = $urandom_range(1, 6);
      tx = $urandom;
      ty = $urandom;
      wide_mode = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
         if (wide_mode) begin
            sx = $urandom;
            sy = $urandom;
         end else begin
            spread = $urandom_range(0, 30);
            sx = tx + ($urandom >> (31 - spread)) - (32'd1 << spread);
            sy = ty + ($urandom >> (31 - spread)) - (32'd1 << spread);
         end
         // coincident source now and then
         if ($urandom_range(0, 19) == 0) begin
            sx = tx;
            sy = ty;
         end
         m = $urandom >> $urandom_range(0, 31);
         pending_bodies.push_back(mk_body(tx, ty, sx, sy, m,
                                          $urandom_range(0, 9) == 0,
                                          (i == 0) ? ($urandom_range(0, 15) != 0)
                                                   : ($urandom_range(0, 31) == 0),
                                          (i == len - 1) ? ($urandom_range(0, 15) != 0)
                                                         : ($urandom_range(0, 31) == 0)));
      end
   endtask

   task automatic add_random_phase(int n);
      int target;
      target = pending_bodies.size() + n;
      while (pending_bodies.size() < target) add_random_set();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed run at the reset value of grav_constant
      no_idle = 1;
      write_grav(GRAV_RESET);
      // single source, first and last on one request
      pending_bodies.push_back(mk_body(0, 0, 32'h0001_0000, 0, 32'h0001_0000, 0, 1, 1));
      // self source at zero distance: adds nothing, sets no flag
      pending_bodies.push_back(mk_body(5, 7, 5, 7, 32'hFFFF_FFFF, 1, 1, 0));
      // coincident non-self source is skipped and flagged
      pending_bodies.push_back(mk_body(5, 7, 5, 7, 100, 0, 0, 0));
      pending_bodies.push_back(mk_body(5, 7, -32'sd3, 7, 32'h0010_0000, 0, 0, 1));
      // extreme spread in both axes, both signs
      pending_bodies.push_back(mk_body(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                       32'h8000_0000, 32'hFFFF_FFFF, 0, 1, 0));
      pending_bodies.push_back(mk_body(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                       32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 1));
      // one-lsb distance with heavy mass saturates the term; the diagonal one lands just inside the clamp
      pending_bodies.push_back(mk_body(0, 0, 1, 0, 32'hFFFF_FFFF, 0, 1, 1));
      pending_bodies.push_back(mk_body(0, 0, -1, -1, 32'hFFFF_FFFF, 0, 1, 1));
      // zero mass contributes zero
      pending_bodies.push_back(mk_body(3, 4, 9, 9, 0, 0, 1, 1));
      // no first mark after a result: starts a fresh sum anyway
      pending_bodies.push_back(mk_body(0, 0, 32'h0002_0000, 32'h0002_0000, 32'h0100_0000,
                                       0, 0, 0));
      // missing first mark: keeps adding
      pending_bodies.push_back(mk_body(0, 0, -32'sh0002_0000, 32'h0001_0000, 32'h0100_0000,
                                       0, 0, 1));
      drain();

      // gravity off, then full scale with a four-source run summed in both axes
      write_grav(32'd0);
      pending_bodies.push_back(mk_body(0, 0, 1, 1, 32'hFFFF_FFFF, 0, 1, 1));
      pending_bodies.push_back(mk_body(0, 0, 0, 0, 1, 0, 1, 1));
      drain();
      write_grav(32'hFFFF_FFFF);
      for (int i = 0; i < 4; i++)
         pending_bodies.push_back(mk_body(0, 0, 32'h0000_0100, -32'sh0000_0100,
                                          32'h0000_4000, 0, i == 0, i == 3));
      pending_bodies.push_back(mk_body(0, 0, 32'h0000_0100, 0, 32'hFFFF_FFFF, 1, 1, 1));
      drain();

      // random phases over several constants
      no_idle = 0;
      write_grav(32'h0001_0000);
      add_random_phase(RAND_PER_PHASE);
      drain();

      // receiver holds off while the sender keeps offering
      write_grav(32'h0000_0001);
      add_random_phase(RAND_PER_PHASE);
      hold_left = HOLD_CYCLES;
      drain();

      write_grav(32'hFFFF_FFFF);
      add_random_phase(RAND_PER_PHASE);
      drain();

      write_grav($urandom);
      no_idle = 1;
      add_random_phase(RAND_PER_PHASE / 2);
      drain();
      no_idle = 0;
      add_random_phase(RAND_PER_PHASE / 2);
      drain();

      write_grav(32'd0);
      add_random_phase(RAND_PER_PHASE / 2);
      drain();

      $display("covered %0d source requests, %0d accelerations, %0d csr writes",
               n_accepted, n_results, n_writes);
      $display("responses with coincident flag: %0d, with saturation: %0d, mismatches: %0d",
               n_coinc, n_sat, n_mismatch);
      if (n_mismatch == 0 && expected_accels.size() == 0) begin
         $display("** pairwise_gravity_accumulator_2d: PASSED **");
      end else begin
         $display("** pairwise_gravity_accumulator_2d: FAILED **");
      end
      $finish;
   end

endmodule

@@ pairwise_gravity_accumulator_2d.f @@
+incdir+rtl/core
rtl/core/pga_pkg.sv
rtl/core/pga_ctrl.sv
rtl/core/pga_datapath.sv
rtl/core/pairwise_gravity_accumulator_2d.sv
test/tb_pairwise_gravity_accumulator_2d.sv
